// ===== hdl/ffsa_pkg.sv =====
// Shared types and constants for the first-fit slot run allocator.
package ffsa_pkg;

  localparam int ROW_W   = 8;
  localparam int ROW_LOG = 3;
  localparam int HS_W    = 8;
  localparam logic [HS_W-1:0] HS_RESET = 8'd64;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_HEAP   = 2'd1,
    ST_BAD_COUNT = 2'd2,
    ST_WAS_FREE  = 2'd3
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] count;
    logic [9:0] free_offset;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [9:0] offset;
    logic [2:0] heap_number;
    logic [6:0] local_index;
    logic       grew;
  } rsp_t;

  typedef enum logic [1:0] {
    PASS_CLEAR = 2'd0,
    PASS_FREE  = 2'd1,
    PASS_GROW  = 2'd2,
    PASS_MARK  = 2'd3
  } pass_sel_t;

  typedef enum logic [1:0] {
    RSP_ALLOC   = 2'd0,
    RSP_FREE    = 2'd1,
    RSP_BAD     = 2'd2,
    RSP_NO_HEAP = 2'd3
  } rsp_sel_t;

  typedef struct packed {
    logic      scan_start;
    logic      pass_start;
    pass_sel_t pass_sel;
    logic      grow;
    logic      div_start;
    logic      rsp_req;
    rsp_sel_t  rsp_sel;
  } cmd_t;

  typedef struct packed {
    logic bad_count;
    logic is_free;
    logic bitmap_empty;
    logic heaps_full;
    logic scan_done;
    logic scan_hit;
    logic pass_done;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/first_fit_slot_run_allocator.sv =====
// Top level of the first-fit slot run allocator.
// One request at a time. After reset a clearing pass writes the bitmap
// memory one row of 8 slots a cycle with in_stall high. An allocate runs
// a row-wise first-fit scan over the bitmap in use (total = heaps in use *
// heap_size), then marks the run; when the scan finds no run or the bitmap
// is empty, a heap is added and its rows are cleared before the mark; then
// the heap/local split is made by repeated subtraction. A full bitmap at
// the defaults holds 512 slots. A free clears its range of the bitmap; a
// bad count is answered without a pass over the bitmap. The memory reads
// one row and writes one row per cycle. The result sits in an output
// register, so the next request is taken while the previous result is
// still stalled.
module first_fit_slot_run_allocator #(
  parameter int MAX_HEAPS      = 8,
  parameter int MAX_HEAP_SLOTS = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ffsa_pkg::req_t            in_req,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ffsa_pkg::rsp_t            out_rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ffsa_pkg::HS_W-1:0] cfg_data
);

  ffsa_pkg::cmd_t  cmd;
  ffsa_pkg::stat_t stat;
  logic            in_accept;

  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  ffsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  ffsa_dpath #(
    .MAX_HEAPS      (MAX_HEAPS),
    .MAX_HEAP_SLOTS (MAX_HEAP_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_req    (in_req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

// ===== hdl/ffsa_div.sv =====
// Repeated-subtraction divider giving heap number and local index of a slot.
module ffsa_div #(
  parameter int PW = 12,
  parameter int HW = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [PW-1:0]             dividend,
  input  logic [ffsa_pkg::HS_W-1:0] divisor,
  output logic                      done,
  output logic [HW-1:0]             quo,
  output logic [ffsa_pkg::HS_W-1:0] rem
);

  logic          busy_r;
  logic [PW-1:0] rem_r;
  logic [HW-1:0] quo_r;
  logic          ge;

  assign ge   = rem_r >= PW'(divisor);
  assign done = busy_r && !ge;
  assign quo  = quo_r;
  assign rem  = ffsa_pkg::HS_W'(rem_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && !ge) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      quo_r <= '0;
    end else if (busy_r && ge) begin
      rem_r <= rem_r - PW'(divisor);
      quo_r <= quo_r + HW'(1);
    end
  end

endmodule

// ===== hdl/ffsa_dpath.sv =====
// Datapath: slot bitmap memory, run scan, range passes, heap count and result register.
module ffsa_dpath #(
  parameter int MAX_HEAPS      = 8,
  parameter int MAX_HEAP_SLOTS = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_accept,
  input  ffsa_pkg::req_t            in_req,
  input  logic                      cfg_we,
  input  logic [ffsa_pkg::HS_W-1:0] cfg_data,
  input  ffsa_pkg::cmd_t            cmd,
  output ffsa_pkg::stat_t           stat,
  input  logic                      out_stall,
  output logic                      out_valid,
  output ffsa_pkg::rsp_t            out_rsp
);

  localparam int RW    = ffsa_pkg::ROW_W;
  localparam int RL    = ffsa_pkg::ROW_LOG;
  localparam int TOTAL = MAX_HEAPS * MAX_HEAP_SLOTS;
  localparam int ROWS  = (TOTAL + RW - 1) / RW;
  localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RCW   = $clog2(ROWS + 1);
  localparam int PW    = $clog2(TOTAL + 2048);
  localparam int HW    = $clog2(MAX_HEAPS + 1);
  localparam int HSW   = ffsa_pkg::HS_W;

  // bitmap memory
  logic [RW-1:0]  mem [ROWS];
  logic [RW-1:0]  rd_data_r;
  logic [RAW-1:0] rd_addr;

  logic [HSW-1:0] hs_cfg_r;
  logic [HSW-1:0] hs_eff;
  logic [HSW-1:0] hs_r;
  logic [HW-1:0]  heaps_r;
  ffsa_pkg::req_t req_r;
  logic [PW-1:0]  total_r;
  logic [PW-1:0]  start_r;
  logic           grew_r;

  logic [PW-1:0]  free_end, free_hi, free_lo;
  logic           free_out;

  logic [PW-1:0]  pass_lo, pass_hi;
  logic [PW-1:0]  pass_lo_r, pass_hi_r;
  logic           pass_set_r;
  logic           pass_act_r;
  logic           pass_nil_r;
  logic [RCW-1:0] pass_row_r, pass_last_r;
  logic           wr_v_r;
  logic [RCW-1:0] wr_row_r;
  logic           flag_r;
  logic [RW-1:0]  wr_bits;
  logic           hole_c;
  logic           in_rng;
  logic [PW-1:0]  wpos_c;

  logic           scan_act_r, scan_vld_r;
  logic [RCW-1:0] scan_row_r, proc_row_r;
  logic [7:0]     run_r;
  logic           scan_issue;
  logic [7:0]     run_c;
  logic           hit_c;
  logic [PW-1:0]  end_c, pos_c;
  logic           scan_last;
  logic           scan_done;

  logic           div_done;
  logic [HW-1:0]  div_quo;
  logic [HSW-1:0] div_rem;

  logic           out_valid_r;
  ffsa_pkg::rsp_t out_rsp_r;
  ffsa_pkg::rsp_t rsp_nxt;
  logic           out_free;
  logic           rsp_load;

  always_comb begin
    if (hs_cfg_r == '0) begin
      hs_eff = HSW'(1);
    end else if (int'(hs_cfg_r) > MAX_HEAP_SLOTS) begin
      hs_eff = HSW'(MAX_HEAP_SLOTS);
    end else begin
      hs_eff = hs_cfg_r;
    end
  end

  // free range clipped to the bitmap in use
  assign free_end = PW'(req_r.free_offset) + PW'(req_r.count);
  assign free_out = free_end > total_r;
  assign free_hi  = free_out ? total_r : free_end;
  assign free_lo  = (PW'(req_r.free_offset) > free_hi) ? free_hi : PW'(req_r.free_offset);

  always_comb begin
    case (cmd.pass_sel)
      ffsa_pkg::PASS_CLEAR: begin
        pass_lo = '0;
        pass_hi = PW'(ROWS * RW);
      end
      ffsa_pkg::PASS_FREE: begin
        pass_lo = free_lo;
        pass_hi = free_hi;
      end
      ffsa_pkg::PASS_GROW: begin
        pass_lo = total_r;
        pass_hi = total_r + PW'(hs_r);
      end
      default: begin
        pass_lo = start_r;
        pass_hi = start_r + PW'(req_r.count);
      end
    endcase
  end

  always_comb begin
    hole_c  = 1'b0;
    wr_bits = '0;
    in_rng  = 1'b0;
    wpos_c  = '0;
    for (int j = 0; j < RW; j++) begin
      wpos_c     = (PW'(wr_row_r) << RL) | PW'(j);
      in_rng     = (wpos_c >= pass_lo_r) && (wpos_c < pass_hi_r);
      wr_bits[j] = in_rng ? pass_set_r : rd_data_r[j];
      if (in_rng && !rd_data_r[j]) begin
        hole_c = 1'b1;
      end
    end
  end

  // run count over one row, carried from the previous row
  always_comb begin
    run_c = run_r;
    hit_c = 1'b0;
    end_c = '0;
    pos_c = '0;
    for (int j = 0; j < RW; j++) begin
      pos_c = (PW'(proc_row_r) << RL) | PW'(j);
      if (!hit_c && pos_c < total_r) begin
        if (rd_data_r[j]) begin
          run_c = '0;
        end else begin
          run_c = run_c + 8'd1;
          if (run_c == req_r.count) begin
            hit_c = 1'b1;
            end_c = pos_c;
          end
        end
      end
    end
  end

  assign scan_issue = scan_act_r && ((PW'(scan_row_r) << RL) < total_r);
  assign scan_last  = ((PW'(proc_row_r) + PW'(1)) << RL) >= total_r;
  assign scan_done  = scan_vld_r && (hit_c || scan_last);
  assign rd_addr    = pass_act_r ? pass_row_r[RAW-1:0] : scan_row_r[RAW-1:0];

  always_ff @(posedge clk) begin
    if (wr_v_r) begin
      mem[wr_row_r[RAW-1:0]] <= wr_bits;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_cfg_r    <= ffsa_pkg::HS_RESET;
      heaps_r     <= '0;
      pass_act_r  <= 1'b0;
      pass_nil_r  <= 1'b0;
      wr_v_r      <= 1'b0;
      scan_act_r  <= 1'b0;
      scan_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        hs_cfg_r <= cfg_data;
      end
      if (cmd.grow) begin
        heaps_r <= heaps_r + HW'(1);
      end

      pass_nil_r <= 1'b0;
      wr_v_r     <= pass_act_r;
      if (cmd.pass_start) begin
        pass_act_r <= pass_lo < pass_hi;
        pass_nil_r <= !(pass_lo < pass_hi);
      end else if (pass_act_r && pass_row_r == pass_last_r) begin
        pass_act_r <= 1'b0;
      end

      if (cmd.scan_start) begin
        scan_act_r <= 1'b1;
        scan_vld_r <= 1'b0;
      end else if (scan_done) begin
        scan_act_r <= 1'b0;
        scan_vld_r <= 1'b0;
      end else begin
        scan_vld_r <= scan_issue;
        if (!scan_issue) begin
          scan_act_r <= 1'b0;
        end
      end

      if (rsp_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r   <= in_req;
      hs_r    <= hs_eff;
      total_r <= PW'(heaps_r) * PW'(hs_eff);
      grew_r  <= 1'b0;
    end
    if (cmd.grow) begin
      start_r <= total_r;
      grew_r  <= 1'b1;
    end else if (scan_done && hit_c) begin
      start_r <= end_c + PW'(1) - PW'(req_r.count);
    end

    if (cmd.pass_start) begin
      pass_lo_r   <= pass_lo;
      pass_hi_r   <= pass_hi;
      pass_set_r  <= cmd.pass_sel == ffsa_pkg::PASS_MARK;
      pass_row_r  <= RCW'(pass_lo >> RL);
      pass_last_r <= RCW'((pass_hi - PW'(1)) >> RL);
      flag_r      <= (cmd.pass_sel == ffsa_pkg::PASS_FREE) && free_out;
    end else begin
      if (pass_act_r) begin
        pass_row_r <= pass_row_r + RCW'(1);
      end
      if (wr_v_r && hole_c) begin
        flag_r <= 1'b1;
      end
    end
    wr_row_r <= pass_row_r;

    if (cmd.scan_start) begin
      scan_row_r <= '0;
      run_r      <= '0;
    end else begin
      if (scan_issue) begin
        scan_row_r <= scan_row_r + RCW'(1);
      end
      if (scan_vld_r) begin
        run_r <= run_c;
      end
    end
    proc_row_r <= scan_row_r;

    if (rsp_load) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  ffsa_div #(
    .PW(PW),
    .HW(HW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (start_r),
    .divisor  (hs_r),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_comb begin
    rsp_nxt = '0;
    case (cmd.rsp_sel)
      ffsa_pkg::RSP_ALLOC: begin
        rsp_nxt.status      = ffsa_pkg::ST_OK;
        rsp_nxt.offset      = 10'(start_r);
        rsp_nxt.heap_number = 3'(div_quo);
        rsp_nxt.local_index = 7'(div_rem);
        rsp_nxt.grew        = grew_r;
      end
      ffsa_pkg::RSP_FREE: begin
        rsp_nxt.status = flag_r ? ffsa_pkg::ST_WAS_FREE : ffsa_pkg::ST_OK;
      end
      ffsa_pkg::RSP_BAD: begin
        rsp_nxt.status = ffsa_pkg::ST_BAD_COUNT;
      end
      default: begin
        rsp_nxt.status = ffsa_pkg::ST_NO_HEAP;
      end
    endcase
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign rsp_load  = cmd.rsp_req && out_free;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign stat.bad_count    = (req_r.count == '0) || (req_r.count > hs_r);
  assign stat.is_free      = req_r.kind == ffsa_pkg::KIND_FREE;
  assign stat.bitmap_empty = total_r == '0;
  assign stat.heaps_full   = heaps_r == HW'(MAX_HEAPS);
  assign stat.scan_done    = scan_done;
  assign stat.scan_hit     = scan_done && hit_c;
  assign stat.pass_done    = (wr_v_r && wr_row_r == pass_last_r) || pass_nil_r;
  assign stat.div_done     = div_done;
  assign stat.out_free     = out_free;

  a_scan_pass_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(pass_act_r && scan_act_r))
    else $error("scan and range pass active together");

  a_hit_in_bitmap: assert property (@(posedge clk) disable iff (!rst_n)
    stat.scan_hit |=> (start_r + PW'(req_r.count)) <= total_r)
    else $error("found run extends beyond bitmap in use");

  a_grow_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grow |-> heaps_r < HW'(MAX_HEAPS))
    else $error("heap added with all heaps in use");

  a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (PW'(div_quo) * PW'(hs_r) + PW'(div_rem)) == start_r)
    else $error("heap number and local index do not rebuild the offset");

endmodule

// ===== hdl/ffsa_ctrl.sv =====
// Controller: sequences the clearing pass, check, scan, grow, mark, free, divide and result steps.
module ffsa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_accept,
  input  ffsa_pkg::stat_t stat,
  output ffsa_pkg::cmd_t  cmd,
  output logic            in_stall
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_GROW,
    S_MARK,
    S_FREE,
    S_DIV,
    S_RESP
  } state_t;

  state_t         state_r;
  ffsa_pkg::cmd_t cmd_r;
  logic           stall_r;

  assign cmd      = cmd_r;
  assign in_stall = stall_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_CLEAR;
      cmd_r            <= '0;
      cmd_r.pass_start <= 1'b1;
      cmd_r.pass_sel   <= ffsa_pkg::PASS_CLEAR;
      stall_r          <= 1'b1;
    end else begin
      cmd_r.scan_start <= 1'b0;
      cmd_r.pass_start <= 1'b0;
      cmd_r.grow       <= 1'b0;
      cmd_r.div_start  <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          if (stat.pass_done) begin
            state_r <= S_IDLE;
            stall_r <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            state_r <= S_CHECK;
            stall_r <= 1'b1;
          end
        end
        S_CHECK: begin
          if (stat.bad_count) begin
            state_r       <= S_RESP;
            cmd_r.rsp_req <= 1'b1;
            cmd_r.rsp_sel <= ffsa_pkg::RSP_BAD;
          end else if (stat.is_free) begin
            state_r          <= S_FREE;
            cmd_r.pass_start <= 1'b1;
            cmd_r.pass_sel   <= ffsa_pkg::PASS_FREE;
          end else if (!stat.bitmap_empty) begin
            state_r          <= S_SCAN;
            cmd_r.scan_start <= 1'b1;
          end else if (stat.heaps_full) begin
            state_r       <= S_RESP;
            cmd_r.rsp_req <= 1'b1;
            cmd_r.rsp_sel <= ffsa_pkg::RSP_NO_HEAP;
          end else begin
            state_r          <= S_GROW;
            cmd_r.grow       <= 1'b1;
            cmd_r.pass_start <= 1'b1;
            cmd_r.pass_sel   <= ffsa_pkg::PASS_GROW;
          end
        end
        S_SCAN: begin
          if (stat.scan_done) begin
            if (stat.scan_hit) begin
              state_r          <= S_MARK;
              cmd_r.pass_start <= 1'b1;
              cmd_r.pass_sel   <= ffsa_pkg::PASS_MARK;
            end else if (stat.heaps_full) begin
              state_r       <= S_RESP;
              cmd_r.rsp_req <= 1'b1;
              cmd_r.rsp_sel <= ffsa_pkg::RSP_NO_HEAP;
            end else begin
              state_r          <= S_GROW;
              cmd_r.grow       <= 1'b1;
              cmd_r.pass_start <= 1'b1;
              cmd_r.pass_sel   <= ffsa_pkg::PASS_GROW;
            end
          end
        end
        S_GROW: begin
          if (stat.pass_done) begin
            state_r          <= S_MARK;
            cmd_r.pass_start <= 1'b1;
            cmd_r.pass_sel   <= ffsa_pkg::PASS_MARK;
          end
        end
        S_MARK: begin
          if (stat.pass_done) begin
            state_r         <= S_DIV;
            cmd_r.div_start <= 1'b1;
          end
        end
        S_DIV: begin
          if (stat.div_done) begin
            state_r       <= S_RESP;
            cmd_r.rsp_req <= 1'b1;
            cmd_r.rsp_sel <= ffsa_pkg::RSP_ALLOC;
          end
        end
        S_FREE: begin
          if (stat.pass_done) begin
            state_r       <= S_RESP;
            cmd_r.rsp_req <= 1'b1;
            cmd_r.rsp_sel <= ffsa_pkg::RSP_FREE;
          end
        end
        S_RESP: begin
          if (stat.out_free) begin
            state_r       <= S_IDLE;
            cmd_r.rsp_req <= 1'b0;
            stall_r       <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
          stall_r <= 1'b0;
        end
      endcase
    end
  end

endmodule
